/* design/sexl_pkg.sv */
// Shared types and constants for the S-expression lexer.
package sexl_pkg;

  localparam logic [3:0] K_SYMCHAR = 4'd0;
  localparam logic [3:0] K_SYMEND  = 4'd1;
  localparam logic [3:0] K_STRCHAR = 4'd2;
  localparam logic [3:0] K_STREND  = 4'd3;
  localparam logic [3:0] K_INT     = 4'd4;
  localparam logic [3:0] K_FLOAT   = 4'd5;
  localparam logic [3:0] K_NIL     = 4'd6;
  localparam logic [3:0] K_T       = 4'd7;
  localparam logic [3:0] K_OPEN    = 4'd8;
  localparam logic [3:0] K_CLOSE   = 4'd9;
  localparam logic [3:0] K_HASH    = 4'd10;
  localparam logic [3:0] K_QUOTE   = 4'd11;
  localparam logic [3:0] K_DOT     = 4'd12;
  localparam logic [3:0] K_EOF     = 4'd13;
  localparam logic [3:0] K_ERROR   = 4'd14;

  localparam int MAX_RES = 5;

  // One result token.
  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         text_char;
    logic signed [31:0] int_value;
    logic               negative;
    logic [29:0]        frac_value;
    logic [3:0]         frac_digits;
  } tok_t;

  // All results of one input byte.
  typedef struct packed {
    logic [2:0]           count;
    tok_t [MAX_RES-1:0]   toks;
  } burst_t;

endpackage

/* design/sexl_front.sv */
// Lexer front: per-byte state machine producing a burst of up to five tokens.
module sexl_front #(
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic [7:0]        ch,
  output logic              stall,
  output logic              q_valid,
  output sexl_pkg::burst_t  q_data,
  input  logic              q_full
);

  localparam logic [3:0] M_START   = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_STRING  = 4'd2;
  localparam logic [3:0] M_NUM     = 4'd3;
  localparam logic [3:0] M_NUMDOT  = 4'd4;
  localparam logic [3:0] M_FRAC    = 4'd5;
  localparam logic [3:0] M_DOT     = 4'd6;
  localparam logic [3:0] M_OP1     = 4'd7;
  localparam logic [3:0] M_OP2     = 4'd8;
  localparam logic [3:0] M_SYM     = 4'd9;
  localparam logic [3:0] M_SYMRUN  = 4'd10;
  localparam logic [3:0] M_ERROR   = 4'd11;

  logic [3:0]  mode, mode_next;
  logic [31:0] int_accum, int_accum_next;
  logic        minus_seen, minus_seen_next;
  logic [29:0] frac_accum, frac_accum_next;
  logic [3:0]  frac_count, frac_count_next;
  logic [7:0]  held [3];
  logic [7:0]  held_next [3];
  logic [1:0]  held_count, held_count_next;
  logic [7:0]  pending_op, pending_op_next;
  sexl_pkg::burst_t b;

  logic fire;
  assign stall = q_full;
  assign fire  = valid && !q_full;
  assign q_valid = fire;
  assign q_data  = b;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
  endfunction
  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
  endfunction
  function automatic logic is_term(input logic [7:0] c);
    return c == 8'd40 || c == 8'd32 || c == 8'd41 || c == 8'd10 || c == 8'd9 || c == 8'd0;
  endfunction
  function automatic logic is_num_delim(input logic [7:0] c);
    return c == 8'd40 || c == 8'd41 || c == 8'd32 || c == 8'd10 || c == 8'd44 || c == 8'd0;
  endfunction

  logic [3:0]  dig;
  logic [31:0] neg_int;
  logic        do_begin;
  assign dig = ch[3:0] - 4'd0;
  assign neg_int = minus_seen ? 32'd0 - int_accum : int_accum;

  always_comb begin
    sexl_pkg::tok_t t;
    t = '0;
    b = '0;
    mode_next = mode;
    int_accum_next = int_accum;
    minus_seen_next = minus_seen;
    frac_accum_next = frac_accum;
    frac_count_next = frac_count;
    held_next = held;
    held_count_next = held_count;
    pending_op_next = pending_op;
    do_begin = 1'b0;

    unique case (mode)
      M_COMMENT: begin
        if (ch == 8'd10) mode_next = M_START;
        else if (ch == 8'd0) begin
          t.kind = sexl_pkg::K_EOF; b.toks[0] = t; b.count = 3'd1; mode_next = M_START;
        end
      end
      M_STRING: begin
        if (ch == 8'd34) begin
          t.kind = sexl_pkg::K_STREND; b.toks[0] = t; b.count = 3'd1; mode_next = M_START;
        end else if (ch == 8'd0) begin
          t.kind = sexl_pkg::K_ERROR; b.toks[0] = t; b.count = 3'd1; mode_next = M_START;
        end else begin
          t.kind = sexl_pkg::K_STRCHAR; t.text_char = ch; b.toks[0] = t; b.count = 3'd1;
        end
      end
      M_NUM: begin
        if (is_digit(ch)) int_accum_next = int_accum * 32'd10 + {28'd0, dig};
        else if (ch == 8'd46) mode_next = M_NUMDOT;
        else if (is_num_delim(ch)) begin
          t.kind = sexl_pkg::K_INT; t.int_value = neg_int; b.toks[0] = t; b.count = 3'd1;
          do_begin = 1'b1;
        end else begin
          t.kind = sexl_pkg::K_ERROR; b.toks[0] = t; b.count = 3'd1;
          mode_next = (ch == 8'd0) ? M_START : M_ERROR;
        end
      end
      M_NUMDOT: begin
        if (is_digit(ch)) begin
          frac_accum_next = {26'd0, dig}; frac_count_next = 4'd1; mode_next = M_FRAC;
        end else begin
          t.kind = sexl_pkg::K_INT; t.int_value = neg_int; b.toks[0] = t; b.count = 3'd1;
          do_begin = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(ch)) begin
          if (frac_count < 4'(MAX_FRAC_DIGITS)) begin
            frac_accum_next = 30'(frac_accum * 30'd10 + {26'd0, dig});
            frac_count_next = frac_count + 4'd1;
          end
        end else begin
          t.kind = sexl_pkg::K_FLOAT; t.int_value = int_accum; t.negative = minus_seen;
          t.frac_value = frac_accum; t.frac_digits = frac_count;
          b.toks[0] = t; b.count = 3'd1; do_begin = 1'b1;
        end
      end
      M_DOT: begin
        if (ch == 8'd32 || ch == 8'd10 || ch == 8'd9) begin
          t.kind = sexl_pkg::K_DOT; b.toks[0] = t; b.count = 3'd1; mode_next = M_START;
        end else if (is_digit(ch)) begin
          int_accum_next = '0; minus_seen_next = 1'b0;
          frac_accum_next = {26'd0, dig}; frac_count_next = 4'd1; mode_next = M_FRAC;
        end else if (ch == 8'd0) begin
          t.kind = sexl_pkg::K_EOF; b.toks[0] = t; b.count = 3'd1; mode_next = M_START;
        end else begin
          t.kind = sexl_pkg::K_ERROR; b.toks[0] = t; b.count = 3'd1; mode_next = M_ERROR;
        end
      end
      M_OP1: begin
        if (pending_op == 8'd45 && is_digit(ch)) begin
          minus_seen_next = 1'b1; int_accum_next = {28'd0, dig};
          frac_accum_next = '0; frac_count_next = '0; mode_next = M_NUM;
        end else if (ch == 8'd61 && (pending_op == 8'd60 || pending_op == 8'd62 ||
                     pending_op == 8'd61 || pending_op == 8'd47)) begin
          mode_next = M_OP2;
        end else if (is_term(ch)) begin
          t.kind = sexl_pkg::K_SYMCHAR; t.text_char = pending_op; b.toks[0] = t;
          t = '0; t.kind = sexl_pkg::K_SYMEND; b.toks[1] = t;
          b.count = 3'd2; do_begin = 1'b1;
        end else begin
          t.kind = sexl_pkg::K_ERROR; b.toks[0] = t; b.count = 3'd1; mode_next = M_ERROR;
        end
      end
      M_OP2: begin
        if (is_term(ch)) begin
          t.kind = sexl_pkg::K_SYMCHAR; t.text_char = pending_op; b.toks[0] = t;
          t.text_char = 8'd61; b.toks[1] = t;
          t = '0; t.kind = sexl_pkg::K_SYMEND; b.toks[2] = t;
          b.count = 3'd3; do_begin = 1'b1;
        end else begin
          t.kind = sexl_pkg::K_ERROR; b.toks[0] = t; b.count = 3'd1; mode_next = M_ERROR;
        end
      end
      M_SYM: begin
        if (!is_term(ch)) begin
          if (held_count < 2'd3) begin
            held_next[held_count] = upcase(ch);
            held_count_next = held_count + 2'd1;
          end else begin
            t.kind = sexl_pkg::K_SYMCHAR;
            t.text_char = held[0]; b.toks[0] = t;
            t.text_char = held[1]; b.toks[1] = t;
            t.text_char = held[2]; b.toks[2] = t;
            t.text_char = upcase(ch); b.toks[3] = t;
            b.count = 3'd4; mode_next = M_SYMRUN;
          end
        end else begin
          if (held_count == 2'd3 && held[0] == 8'd78 && held[1] == 8'd73 && held[2] == 8'd76) begin
            t.kind = sexl_pkg::K_NIL; b.toks[0] = t; b.count = 3'd1;
          end else if (held_count == 2'd1 && held[0] == 8'd84) begin
            t.kind = sexl_pkg::K_T; b.toks[0] = t; b.count = 3'd1;
          end else begin
            t.kind = sexl_pkg::K_SYMCHAR;
            t.text_char = held[0]; b.toks[0] = t;
            t.text_char = held[1]; b.toks[1] = t;
            t.text_char = held[2]; b.toks[2] = t;
            t = '0; t.kind = sexl_pkg::K_SYMEND;
            b.toks[held_count] = t;
            b.count = {1'b0, held_count} + 3'd1;
          end
          do_begin = 1'b1;
        end
      end
      M_SYMRUN: begin
        if (!is_term(ch)) begin
          t.kind = sexl_pkg::K_SYMCHAR; t.text_char = upcase(ch); b.toks[0] = t; b.count = 3'd1;
        end else begin
          t.kind = sexl_pkg::K_SYMEND; b.toks[0] = t; b.count = 3'd1; do_begin = 1'b1;
        end
      end
      M_ERROR: begin
        if (ch == 8'd0) mode_next = M_START;
      end
      default: do_begin = 1'b1;
    endcase

    // re-lex the terminating byte from the start state, appending at most one token
    if (do_begin) begin
      t = '0;
      mode_next = M_START;
      if (ch == 8'd32 || ch == 8'd9 || ch == 8'd10 || ch == 8'd11 || ch == 8'd12 ||
          ch == 8'd13) begin
        t.kind = sexl_pkg::K_EOF;
      end else if (ch == 8'd0) begin
        t.kind = sexl_pkg::K_EOF; b.toks[b.count] = t; b.count = b.count + 3'd1;
      end else if (ch == 8'd59) mode_next = M_COMMENT;
      else if (ch == 8'd34) mode_next = M_STRING;
      else if (is_digit(ch)) begin
        int_accum_next = {28'd0, dig}; minus_seen_next = 1'b0;
        frac_accum_next = '0; frac_count_next = '0; mode_next = M_NUM;
      end else if (is_alpha(ch)) begin
        held_next[0] = upcase(ch); held_count_next = 2'd1; mode_next = M_SYM;
      end else if (ch == 8'd40) begin
        t.kind = sexl_pkg::K_OPEN; b.toks[b.count] = t; b.count = b.count + 3'd1;
      end else if (ch == 8'd41) begin
        t.kind = sexl_pkg::K_CLOSE; b.toks[b.count] = t; b.count = b.count + 3'd1;
      end else if (ch == 8'd35) begin
        t.kind = sexl_pkg::K_HASH; b.toks[b.count] = t; b.count = b.count + 3'd1;
      end else if (ch == 8'd39) begin
        t.kind = sexl_pkg::K_QUOTE; b.toks[b.count] = t; b.count = b.count + 3'd1;
      end else if (ch == 8'd46) mode_next = M_DOT;
      else if (ch == 8'd45 || ch == 8'd60 || ch == 8'd62 || ch == 8'd61 || ch == 8'd47 ||
               ch == 8'd43 || ch == 8'd42) begin
        pending_op_next = ch; mode_next = M_OP1;
      end else begin
        t.kind = sexl_pkg::K_ERROR; b.toks[b.count] = t; b.count = b.count + 3'd1;
        mode_next = M_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START;
      int_accum <= '0;
      minus_seen <= 1'b0;
      frac_accum <= '0;
      frac_count <= '0;
      held_count <= '0;
      pending_op <= '0;
    end else if (fire) begin
      mode <= mode_next;
      int_accum <= int_accum_next;
      minus_seen <= minus_seen_next;
      frac_accum <= frac_accum_next;
      frac_count <= frac_count_next;
      held_count <= held_count_next;
      pending_op <= pending_op_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) held <= held_next;
  end

endmodule

/* design/sexl_queue.sv */
// Small burst FIFO between lexer front and token serializer.
module sexl_queue #(
  parameter int DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sexl_pkg::burst_t in_data,
  output logic             full,
  output logic             out_valid,
  output sexl_pkg::burst_t out_data,
  input  logic             out_pop
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  sexl_pkg::burst_t mem [DEPTH];
  logic [DEPTH_LOG2:0] wr_ptr, rd_ptr;

  assign full      = (wr_ptr - rd_ptr) == (DEPTH_LOG2+1)'(DEPTH);
  assign out_valid = wr_ptr != rd_ptr;
  assign out_data  = mem[rd_ptr[DEPTH_LOG2-1:0]];

  always_ff @(posedge clk) begin
    if (in_valid) mem[wr_ptr[DEPTH_LOG2-1:0]] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (in_valid) wr_ptr <= wr_ptr + 1'b1;
      if (out_pop) rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

/* design/sexl_back.sv */
// Lexer back: serializes each burst into output token beats with a last flag.
module sexl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sexl_pkg::burst_t   q_data,
  output logic               q_pop,
  output logic               valid,
  input  logic               stall,
  output logic [3:0]         kind,
  output logic [7:0]         text_char,
  output logic signed [31:0] int_value,
  output logic               negative,
  output logic [29:0]        frac_value,
  output logic [3:0]         frac_digits,
  output logic               last
);

  logic [2:0] idx;
  logic       out_free;
  logic       take;
  logic       is_last;
  logic       empty_burst;
  sexl_pkg::tok_t t;

  assign out_free    = !valid || !stall;
  assign empty_burst = q_data.count == 3'd0;
  assign is_last     = (idx + 3'd1) == q_data.count;
  assign take        = q_valid && out_free && !empty_burst;
  assign q_pop       = q_valid && (empty_burst || (out_free && is_last));
  assign t           = q_data.toks[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (out_free) valid <= take;
      if (q_pop) idx <= '0;
      else if (take) idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind        <= t.kind;
      text_char   <= t.text_char;
      int_value   <= t.int_value;
      negative    <= t.negative;
      frac_value  <= t.frac_value;
      frac_digits <= t.frac_digits;
      last        <= is_last;
    end
  end

endmodule

/* design/s_expression_lexer_core.sv */
// S-expression lexer top level: front, burst queue, output serializer.
// Input: one byte per cycle while the queue has room; a byte's burst is queued at its accept edge.
// Path: an accepted byte's burst is written into the queue memory, then registered beat by beat on the output.
// Output: one token beat per cycle while out_stall is low; a byte that yields n tokens gives n beats,
// a byte with no tokens is popped from the queue with no beat; the input stalls while four bursts are queued.
// Reset (rst, synchronous): lexer returns to start state, queue and output register empty.
module s_expression_lexer_core #(
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic [7:0]         text_char,
  output logic signed [31:0] int_value,
  output logic               negative,
  output logic [29:0]        frac_value,
  output logic [3:0]         frac_digits,
  output logic               last
);

  logic             f_valid, q_full, q_valid, q_pop;
  sexl_pkg::burst_t f_data, q_data;

  sexl_front #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_front (
    .clk, .rst, .valid(in_valid), .ch, .stall(in_stall),
    .q_valid(f_valid), .q_data(f_data), .q_full
  );

  sexl_queue #(.DEPTH_LOG2(2)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_data(f_data), .full(q_full),
    .out_valid(q_valid), .out_data(q_data), .out_pop(q_pop)
  );

  sexl_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop,
    .valid(out_valid), .stall(out_stall), .kind, .text_char, .int_value,
    .negative, .frac_value, .frac_digits, .last
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the S-expression lexer core.
module testbench;

  localparam int FRAC_MAX = 9;
  localparam int WDOG_LIMIT = 2000;

  typedef enum logic [3:0] {
    LX_START, LX_COMMENT, LX_STRING, LX_NUM, LX_NUMDOT, LX_FRAC, LX_DOT,
    LX_OP1, LX_OP2, LX_SYM, LX_SYMRUN, LX_ERROR
  } lex_mode_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         text_char;
    logic signed [31:0] int_value;
    logic               negative;
    logic [29:0]        frac_value;
    logic [3:0]         frac_digits;
    logic               last;
  } token_t;

  class token_board_t;
    lex_mode_t   mode;
    logic [31:0] acc;
    logic        minus;
    logic [29:0] frac;
    logic [3:0]  fcnt;
    logic [7:0]  held [3];
    logic [1:0]  hcnt;
    logic [7:0]  op;
    token_t      pending_tokens[$];
    token_t      burst[$];
    int          errors;
    int          tokens_seen;

    function new();
      mode = LX_START; acc = 0; minus = 0; frac = 0; fcnt = 0;
      hcnt = 0; op = 0; errors = 0; tokens_seen = 0;
      foreach (held[i]) held[i] = 0;
    endfunction

    function void put(logic [3:0] k, logic [7:0] tc = 0, logic [31:0] iv = 0,
                      logic ng = 0, logic [29:0] fv = 0, logic [3:0] fd = 0);
      token_t t;
      t = '{k, tc, iv, ng, fv, fd, 1'b0};
      if (burst.size() < sexl_pkg::MAX_RES) burst.push_back(t);
    endfunction

    function logic [7:0] up(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit term(logic [7:0] c);
      return c == "(" || c == ")" || c == " " || c == 8'd10 || c == 8'd9 || c == 0;
    endfunction

    function void err(logic [7:0] c);
      put(sexl_pkg::K_ERROR);
      mode = (c == 0) ? LX_START : LX_ERROR;
    endfunction

    function void signed_int();
      put(sexl_pkg::K_INT, 0, minus ? 32'd0 - acc : acc);
    endfunction

    function void from_start(logic [7:0] c);
      mode = LX_START;
      if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd11 || c == 8'd12 || c == 8'd13)
        return;
      if (c == 0) begin put(sexl_pkg::K_EOF); return; end
      if (c == ";") begin mode = LX_COMMENT; return; end
      if (c == "\"") begin mode = LX_STRING; return; end
      if (digit(c)) begin
        acc = 32'(c - 8'd48); minus = 0; frac = 0; fcnt = 0; mode = LX_NUM; return;
      end
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
        held[0] = up(c); hcnt = 1; mode = LX_SYM; return;
      end
      case (c)
        "(": put(sexl_pkg::K_OPEN);
        ")": put(sexl_pkg::K_CLOSE);
        "#": put(sexl_pkg::K_HASH);
        "'": put(sexl_pkg::K_QUOTE);
        ".": mode = LX_DOT;
        "-", "<", ">", "=", "/", "+", "*": begin op = c; mode = LX_OP1; end
        default: err(c);
      endcase
    endfunction

    // note an accepted byte and queue the tokens it causes
    function void note_byte(logic [7:0] c);
      burst.delete();
      case (mode)
        LX_COMMENT: begin
          if (c == 8'd10) mode = LX_START;
          else if (c == 0) begin put(sexl_pkg::K_EOF); mode = LX_START; end
        end
        LX_STRING: begin
          if (c == "\"") begin put(sexl_pkg::K_STREND); mode = LX_START; end
          else if (c == 0) err(c);
          else put(sexl_pkg::K_STRCHAR, c);
        end
        LX_NUM: begin
          if (digit(c)) acc = acc * 10 + (c - 8'd48);
          else if (c == ".") mode = LX_NUMDOT;
          else if (term(c) && c != 8'd9 || c == ",") begin signed_int(); from_start(c); end
          else err(c);
        end
        LX_NUMDOT: begin
          if (digit(c)) begin frac = 30'(c - 8'd48); fcnt = 1; mode = LX_FRAC; end
          else begin signed_int(); from_start(c); end
        end
        LX_FRAC: begin
          if (digit(c)) begin
            if (fcnt < FRAC_MAX) begin frac = frac * 10 + (c - 8'd48); fcnt++; end
          end else begin
            put(sexl_pkg::K_FLOAT, 0, acc, minus, frac, fcnt); from_start(c);
          end
        end
        LX_DOT: begin
          if (c == " " || c == 8'd10 || c == 8'd9) begin
            put(sexl_pkg::K_DOT); mode = LX_START;
          end else if (digit(c)) begin
            acc = 0; minus = 0; frac = 30'(c - 8'd48); fcnt = 1; mode = LX_FRAC;
          end else if (c == 0) begin put(sexl_pkg::K_EOF); mode = LX_START; end
          else err(c);
        end
        LX_OP1: begin
          if (op == "-" && digit(c)) begin
            minus = 1; acc = 32'(c - 8'd48); frac = 0; fcnt = 0; mode = LX_NUM;
          end else if (c == "=" && (op == "<" || op == ">" || op == "=" || op == "/"))
            mode = LX_OP2;
          else if (term(c)) begin
            put(sexl_pkg::K_SYMCHAR, op); put(sexl_pkg::K_SYMEND); from_start(c);
          end
          else err(c);
        end
        LX_OP2: begin
          if (term(c)) begin
            put(sexl_pkg::K_SYMCHAR, op); put(sexl_pkg::K_SYMCHAR, "=");
            put(sexl_pkg::K_SYMEND); from_start(c);
          end else err(c);
        end
        LX_SYM: begin
          if (!term(c)) begin
            if (hcnt < 3) begin held[hcnt] = up(c); hcnt++; end
            else begin
              for (int i = 0; i < 3; i++) put(sexl_pkg::K_SYMCHAR, held[i]);
              put(sexl_pkg::K_SYMCHAR, up(c));
              mode = LX_SYMRUN;
            end
          end else begin
            if (hcnt == 3 && held[0] == "N" && held[1] == "I" && held[2] == "L")
              put(sexl_pkg::K_NIL);
            else if (hcnt == 1 && held[0] == "T") put(sexl_pkg::K_T);
            else begin
              for (int i = 0; i < hcnt; i++) put(sexl_pkg::K_SYMCHAR, held[i]);
              put(sexl_pkg::K_SYMEND);
            end
            from_start(c);
          end
        end
        LX_SYMRUN: begin
          if (!term(c)) put(sexl_pkg::K_SYMCHAR, up(c));
          else begin put(sexl_pkg::K_SYMEND); from_start(c); end
        end
        LX_ERROR: if (c == 0) mode = LX_START;
        default: from_start(c);
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) pending_tokens.push_back(burst[i]);
    endfunction

    function void check_token(token_t got);
      token_t want;
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, got %p", $time, got);
        errors++;
        return;
      end
      want = pending_tokens.pop_front();
      if (got.kind !== want.kind)
        begin $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind); errors++; end
      if (got.text_char !== want.text_char)
        begin $display("%0t: text_char exp %h got %h", $time, want.text_char,
                       got.text_char); errors++; end
      if (got.int_value !== want.int_value)
        begin $display("%0t: int_value exp %0d got %0d", $time, want.int_value,
                       got.int_value); errors++; end
      if (got.negative !== want.negative)
        begin $display("%0t: negative exp %b got %b", $time, want.negative,
                       got.negative); errors++; end
      if (got.frac_value !== want.frac_value)
        begin $display("%0t: frac_value exp %0d got %0d", $time, want.frac_value,
                       got.frac_value); errors++; end
      if (got.frac_digits !== want.frac_digits)
        begin $display("%0t: frac_digits exp %0d got %0d", $time, want.frac_digits,
                       got.frac_digits); errors++; end
      if (got.last !== want.last)
        begin $display("%0t: last exp %b got %b", $time, want.last, got.last); errors++; end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 1;
  logic [7:0] ch = 0;
  logic [3:0] kind, frac_digits;
  logic [7:0] text_char;
  logic signed [31:0] int_value;
  logic negative, last;
  logic [29:0] frac_value;

  s_expression_lexer_core dut (.*);

  always #5 clk = ~clk;

  token_board_t board = new();
  int  idle_cycles = 0;
  bit  quiet = 0;
  int  bytes_sent = 0;

  // watchdog and output monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("watchdog expired");
        $display("testbench NOT OK");
        $finish;
      end
      if (out_valid && !out_stall)
        board.check_token('{kind, text_char, int_value, negative, frac_value,
                            frac_digits, last});
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic string pick_token();
    string pool[] = '{"nil", "t", "Foo", "abcdef", "ab", "42", "-17", "3.25",
                      "-0.5", ".75", "7.", "12.x", "\"hi x\"", "(", ")", "#", "'",
                      ". ", "<=", ">", "/=", "==", "+", "*", "-", "x;c\n",
                      "4294967299", "1.1234567891234"};
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic string pick_delim();
    string d[] = '{" ", "\n", "\t", "(", ")", ","};
    return d[$urandom_range(0, d.size() - 1)];
  endfunction

  initial begin
    string s;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: kinds, delimiters, special cases
    send_text("( nil t Abc longsym \"s q\" 12 -34 1.5 -2.25 .5 7.a");
    send_byte(0);
    send_text("' # . <= >= /= == < > = + * / ; note\n5,");
    send_byte(0);
    send_text("12x junk"); send_byte(0);
    send_text("-a");        send_byte(0);
    send_text(".");         send_byte(0);
    send_text("\"open");    send_byte(0);
    send_byte(8'hff); send_byte(8'h80); send_byte(0);
    send_text("0.12345678901 ."); send_byte(8'h7f); send_byte(0);
    drain();
    // random part: mostly well formed token sequences, some noise
    for (int i = 0; bytes_sent < 180; i++) begin
      if (i == 20) drain();
      if (bytes_sent > 150) quiet = 1;
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
      else if ($urandom_range(0, 19) == 0) send_byte(0);
      else begin
        s = pick_token();
        send_text(s);
        send_text(pick_delim());
      end
    end
    send_byte(0);
    drain();
    repeat (20) @(negedge clk);
    $display("Lexed %0d bytes into %0d tokens: all token kinds, numbers, strings,",
             bytes_sent, board.tokens_seen);
    $display("symbols, operators, comments and error recovery, under random stalls.");
    if (board.errors == 0 && board.pending_tokens.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
